>>> sv/tcf_pkg.sv
// Shared types, constants and helper functions for the tick-to-calendar converter.
// Used by tcf_cdiv, tcf_year, tcf_month and ticks_to_calendar_fields_top.
package tcf_pkg;

    // Input tick count width
    localparam int TICK_W = 58;

    // Unit ratios
    localparam int TICKS_PER_MS  = 10000;
    localparam int MS_PER_SEC    = 1000;
    localparam int SEC_PER_MIN   = 60;
    localparam int MIN_PER_HOUR  = 60;
    localparam int HOUR_PER_DAY  = 24;
    localparam int DAYS_PER_YEAR = 365;

    // Quotient bits resolved per divider pipeline stage
    localparam int DIV_STEP = 8;

    // Widths of the running counts (bounded by the 58-bit input)
    localparam int MSEC_CNT_W = 45;
    localparam int SEC_CNT_W  = 35;
    localparam int MIN_CNT_W  = 29;
    localparam int HOUR_CNT_W = 23;
    localparam int DAY_CNT_W  = 19;
    localparam int YEAR_OFS_W = 11;  // days / 365

    // Result field widths
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int MDAY_W  = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MSEC_W  = 10;
    localparam int WDAY_W  = 3;

    // Internal widths
    localparam int DOY_W   = 9;   // day of year, also days % 365
    localparam int YCALC_W = 14;  // full year before range check
    localparam int LEAPS_W = 12;  // leap-year counts
    localparam int CENT_W  = 8;   // (year-1) / 100

    // x / 25 as (x * RECIP25) >> RECIP25_SH, exact for x < 2^12
    localparam int            RECIP_W    = 20;
    localparam logic [19:0]   RECIP25    = 20'd671089;
    localparam int            RECIP25_SH = 24;

    // Days before the first of each month, non-leap year
    localparam logic [DOY_W-1:0] CUM_DAYS [13] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
    };

    // Time of day carried alongside the day count
    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [MSEC_W-1:0] millisecond;
    } tcf_time_t;

    // Year stage to month stage
    typedef struct packed {
        logic                out_of_range;
        logic [YEAR_W-1:0]   year;
        logic [DOY_W-1:0]    doy;
        logic                leap;
        logic [WDAY_W-1:0]   weekday;
        tcf_time_t           tod;
    } tcf_date_t;

    // Final result word
    typedef struct packed {
        logic                out_of_range;
        logic [WDAY_W-1:0]   weekday;
        logic [MSEC_W-1:0]   millisecond;
        logic [SEC_W-1:0]    second;
        logic [MIN_W-1:0]    minute;
        logic [HOUR_W-1:0]   hour;
        logic [MDAY_W-1:0]   day_of_month;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } tcf_result_t;

    // Leap years in 1 .. y-1 (elaboration only)
    function automatic int leaps_before(input int y);
        int p;
        p = (y == 0) ? 0 : y - 1;
        return p / 4 - p / 100 + p / 400;
    endfunction

    // Weekday of 1 January of year b, 0 = Sunday (elaboration only)
    function automatic int base_weekday(input int b);
        return (1 + 365 * ((b - 1) % 7) + leaps_before(b)) % 7;
    endfunction

endpackage

>>> sv/tcf_cdiv.sv
// Pipelined restoring divider by a constant, DIV_STEP quotient bits per stage.
// Carries a side payload with each word. Depends on tcf_pkg.
module tcf_cdiv #(
    parameter int W        = 16,
    parameter int DIVISOR  = 10,
    parameter int SW       = 1,
    localparam int RW      = $clog2(DIVISOR)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  in_dvd,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [W-1:0]  out_quot,
    output logic [RW-1:0] out_rem,
    output logic [SW-1:0] out_side
);
    import tcf_pkg::*;

    localparam int         NS    = (W + DIV_STEP - 1) / DIV_STEP;
    localparam logic [RW:0] DIV_C = DIVISOR[RW:0];

    // Stage links; index 0 is the input
    wire [NS:0]   v_w;
    wire [RW-1:0] r_w [NS+1];
    wire [W-1:0]  d_w [NS+1];
    wire [SW-1:0] s_w [NS+1];

    assign v_w[0] = in_valid;
    assign r_w[0] = '0;
    assign d_w[0] = in_dvd;
    assign s_w[0] = in_side;

    generate
        for (genvar g = 0; g < NS; g++) begin : g_stage
            localparam int N = ((g + 1) * DIV_STEP > W) ? (W - g * DIV_STEP) : DIV_STEP;

            logic          v_reg;
            logic [RW-1:0] r_reg, r_next;
            logic [W-1:0]  d_reg, d_next;
            logic [SW-1:0] s_reg;
            logic [RW:0]   sh, diff;

            // N shift/compare/subtract steps; quotient bits fill the vacated LSBs
            always_comb begin
                r_next = r_w[g];
                d_next = d_w[g];
                sh     = '0;
                diff   = '0;
                for (int i = 0; i < N; i++) begin
                    sh   = {r_next, d_next[W-1]};
                    diff = sh - DIV_C;
                    if (sh >= DIV_C) begin
                        r_next = diff[RW-1:0];
                        d_next = {d_next[W-2:0], 1'b1};
                    end else begin
                        r_next = sh[RW-1:0];
                        d_next = {d_next[W-2:0], 1'b0};
                    end
                end
            end

            // Valid bit
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg <= 1'b0;
                end else if (en) begin
                    v_reg <= v_w[g];
                end
            end

            // Payload
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg <= r_next;
                    d_reg <= d_next;
                    s_reg <= s_w[g];
                end
            end

            assign v_w[g+1] = v_reg;
            assign r_w[g+1] = r_reg;
            assign d_w[g+1] = d_reg;
            assign s_w[g+1] = s_reg;
        end
    endgenerate

    assign out_valid = v_w[NS];
    assign out_quot  = d_w[NS];
    assign out_rem   = r_w[NS];
    assign out_side  = s_w[NS];

endmodule

>>> sv/tcf_year.sv
// Year, day-of-year, leap flag and weekday from days/365 and days%365, three stages.
// Depends on tcf_pkg.
module tcf_year #(
    parameter int EPOCH_YEAR = 1601
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [tcf_pkg::YEAR_OFS_W-1:0] in_yq,
    input  logic [tcf_pkg::DOY_W-1:0]     in_yr,
    input  tcf_pkg::tcf_time_t            in_tod,
    output logic                          out_valid,
    output tcf_pkg::tcf_date_t            out_date
);
    import tcf_pkg::*;

    localparam int                 LB_BASE = leaps_before(EPOCH_YEAR);
    localparam int                 BASE_WD = base_weekday(EPOCH_YEAR);
    localparam logic [YCALC_W-1:0] EPOCH_C = EPOCH_YEAR[YCALC_W-1:0];

    // Mod 7 of an 11-bit value by octal digit folding (8 == 1 mod 7)
    function automatic logic [WDAY_W-1:0] mod7(input logic [10:0] v);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[10:9]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    // ---------------- stage 1: year estimate, century count ----------------
    logic                 v1_reg;
    logic [YCALC_W-1:0]   p1_reg, p1_next;
    logic [CENT_W-1:0]    c1_reg, c1_next;
    logic [DOY_W-1:0]     r1_reg;
    logic [WDAY_W-1:0]    wd1_reg, wd1_next;
    tcf_time_t            tod1_reg;
    logic [YCALC_W-1:0]   y_est;
    logic [31:0]          prod;
    logic [10:0]          wsum;

    always_comb begin
        y_est    = YCALC_W'(in_yq) + EPOCH_C;
        p1_next  = y_est - 1'b1;
        prod     = 32'(p1_next[YCALC_W-1:2]) * 32'(RECIP25);
        c1_next  = prod[RECIP25_SH +: CENT_W];
        // 365 == 1 mod 7, so days mod 7 == (q + r) mod 7
        wsum     = 11'(in_yq) + 11'(in_yr) + 11'(BASE_WD);
        wd1_next = mod7(wsum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= p1_next;
            c1_reg   <= c1_next;
            r1_reg   <= in_yr;
            wd1_reg  <= wd1_next;
            tod1_reg <= in_tod;
        end
    end

    // ---------------- stage 2: leap counts and correction test ----------------
    logic                 v2_reg;
    logic [YCALC_W-1:0]   y2_reg, y2_next;
    logic [DOY_W-1:0]     ld2_reg, ld2_next;
    logic                 lp2_reg, lp2_next;   // year-1 is leap
    logic                 ly2_reg, ly2_next;   // year estimate is leap
    logic                 corr2_reg, corr2_next;
    logic [DOY_W-1:0]     r2_reg;
    logic [WDAY_W-1:0]    wd2_reg;
    tcf_time_t            tod2_reg;
    logic [LEAPS_W-1:0]   x4, lb, ld_full, c25;
    logic [LEAPS_W:0]     x4p1, c25p;

    always_comb begin
        x4       = p1_reg[YCALC_W-1:2];
        // (y-1)/4 - (y-1)/100 + (y-1)/400
        lb       = x4 - LEAPS_W'(c1_reg) + LEAPS_W'(c1_reg[CENT_W-1:2]);
        ld_full  = lb - LEAPS_W'(LB_BASE);
        ld2_next = ld_full[DOY_W-1:0];
        c25      = {c1_reg, 4'b0} + {1'b0, c1_reg, 3'b0} + LEAPS_W'(c1_reg);
        x4p1     = (LEAPS_W+1)'(x4) + 1'b1;
        c25p     = (LEAPS_W+1)'(c25) + (LEAPS_W+1)'(25);
        lp2_next = (p1_reg[1:0] == 2'b00) && ((x4 != c25) || (c1_reg[1:0] == 2'b00));
        ly2_next = (p1_reg[1:0] == 2'b11) && ((x4p1 != c25p) || (c1_reg[1:0] == 2'b11));
        y2_next  = p1_reg + 1'b1;
        corr2_next = (ld2_next > r1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y2_reg    <= y2_next;
            ld2_reg   <= ld2_next;
            lp2_reg   <= lp2_next;
            ly2_reg   <= ly2_next;
            corr2_reg <= corr2_next;
            r2_reg    <= r1_reg;
            wd2_reg   <= wd1_reg;
            tod2_reg  <= tod1_reg;
        end
    end

    // ---------------- stage 3: corrected year and day of year ----------------
    logic                 v3_reg;
    tcf_date_t            date3_reg, date3_next;
    logic [YCALC_W-1:0]   yr;
    logic [DOY_W:0]       doy_w;

    always_comb begin
        if (corr2_reg) begin
            yr    = y2_reg - 1'b1;
            doy_w = (DOY_W+1)'(r2_reg) + (DOY_W+1)'(DAYS_PER_YEAR) + (DOY_W+1)'(lp2_reg)
                    - (DOY_W+1)'(ld2_reg);
            date3_next.leap = lp2_reg;
        end else begin
            yr    = y2_reg;
            doy_w = (DOY_W+1)'(r2_reg) - (DOY_W+1)'(ld2_reg);
            date3_next.leap = ly2_reg;
        end
        date3_next.out_of_range = |yr[YCALC_W-1:YEAR_W];
        date3_next.year         = yr[YEAR_W-1:0];
        date3_next.doy          = doy_w[DOY_W-1:0];
        date3_next.weekday      = wd2_reg;
        date3_next.tod          = tod2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            date3_reg <= date3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_date  = date3_reg;

endmodule

>>> sv/tcf_month.sv
// Month and day of month from day of year, then result assembly; two stages.
// Depends on tcf_pkg.
module tcf_month (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  tcf_pkg::tcf_date_t   in_date,
    output logic                 out_valid,
    output tcf_pkg::tcf_result_t out_res
);
    import tcf_pkg::*;

    // ---------------- stage 1: month by comparing against month starts ----------------
    logic                v1_reg;
    logic [MONTH_W-1:0]  mon1_reg, mon1_next;
    tcf_date_t           date1_reg;
    logic [DOY_W-1:0]    mstart;
    logic [MONTH_W-1:0]  cnt;

    always_comb begin
        cnt    = '0;
        mstart = '0;
        for (int m = 1; m < 12; m++) begin
            mstart = CUM_DAYS[m] + DOY_W'(in_date.leap && (m >= 2));
            if (in_date.doy >= mstart) begin
                cnt = cnt + 1'b1;
            end
        end
        mon1_next = cnt + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mon1_reg  <= mon1_next;
            date1_reg <= in_date;
        end
    end

    // ---------------- stage 2: day of month, output word ----------------
    logic                v2_reg;
    tcf_result_t         res2_reg, res2_next;
    logic [MONTH_W-1:0]  midx;
    logic [DOY_W-1:0]    first_day, dom;

    always_comb begin
        midx      = mon1_reg - 1'b1;
        first_day = CUM_DAYS[midx] + DOY_W'(date1_reg.leap && (mon1_reg > 4'd2));
        dom       = date1_reg.doy - first_day + 1'b1;

        res2_next = '0;
        if (date1_reg.out_of_range) begin
            res2_next.out_of_range = 1'b1;
        end else begin
            res2_next.year         = date1_reg.year;
            res2_next.month        = mon1_reg;
            res2_next.day_of_month = dom[MDAY_W-1:0];
            res2_next.hour         = date1_reg.tod.hour;
            res2_next.minute       = date1_reg.tod.minute;
            res2_next.second       = date1_reg.tod.second;
            res2_next.millisecond  = date1_reg.tod.millisecond;
            res2_next.weekday      = date1_reg.weekday;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res2_reg <= res2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_res   = res2_reg;

endmodule

>>> sv/ticks_to_calendar_fields_top.sv
// Tick count to Gregorian calendar fields, stream in / stream out.
// Depends on tcf_pkg, tcf_cdiv, tcf_year and tcf_month.
//
// Usage:
//   s_* channel: one 64-bit word per timestamp, tick count (100 ns units since
//   1 January of EPOCH_YEAR) in s_tdata[57:0]; bits above are ignored.
//   m_* channel: one word per input word, in order. m_tdata holds the calendar
//   fields, m_tuser flags a year above 4095, in which case m_tdata is zero.
//   The pipeline from accept to m_tvalid is 29 stages of constant
//   dividers (/10000, /1000, /60, /60, /24, /365, each resolving eight
//   quotient bits per stage), 3 year stages and 2 month stages.
//   Throughput is one word per cycle while the output is not stalled.
//   The whole pipeline advances together; when m_tvalid is high and m_tready
//   low, every stage holds and s_tready drops, so nothing is lost or repeated.
//   s_tready is high whenever the output register is empty or being drained.
//   Reset (aresetn low, synchronous) clears all valid bits; data registers are
//   not reset.
module ticks_to_calendar_fields_top #(
    parameter int EPOCH_YEAR = 1601
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [57:0] tick_count, [63:58] zero fill
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month,
                                   // [25:21] hour, [31:26] minute, [37:32] second,
                                   // [47:38] millisecond, [50:48] weekday, [55:51] zero
    output logic        m_tuser    // [0] out_of_range
);
    import tcf_pkg::*;

    logic en;
    logic in_valid;

    // Global advance: output register empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign in_valid = s_tvalid && s_tready;

    // ---------------- divider chain ----------------
    logic                  v_ms, v_s, v_min, v_hr, v_day;
    logic [TICK_W-1:0]     q_ms;
    logic [MSEC_CNT_W-1:0] q_s;
    logic [SEC_CNT_W-1:0]  q_min;
    logic [MIN_CNT_W-1:0]  q_hr;
    logic [HOUR_CNT_W-1:0] q_day;
    logic [DAY_CNT_W-1:0]  q_yr;
    logic [MSEC_W-1:0]     ms_s, ms_min, ms_hr;
    logic [SEC_W-1:0]      sec_min, sec_hr;
    logic [MIN_W-1:0]      min_hr;
    logic [HOUR_W-1:0]     hr_day;
    logic [DOY_W-1:0]      r_yr;
    logic                  v_yr;
    tcf_time_t             tod_day, tod_yr;

    tcf_cdiv #(.W(TICK_W), .DIVISOR(TICKS_PER_MS), .SW(1)) u_div_ms (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(in_valid), .in_dvd(s_tdata[TICK_W-1:0]), .in_side(1'b0),
        .out_valid(v_ms), .out_quot(q_ms), .out_rem(), .out_side()
    );

    tcf_cdiv #(.W(MSEC_CNT_W), .DIVISOR(MS_PER_SEC), .SW(1)) u_div_sec (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_ms), .in_dvd(q_ms[MSEC_CNT_W-1:0]), .in_side(1'b0),
        .out_valid(v_s), .out_quot(q_s), .out_rem(ms_s), .out_side()
    );

    tcf_cdiv #(.W(SEC_CNT_W), .DIVISOR(SEC_PER_MIN), .SW(MSEC_W)) u_div_min (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_s), .in_dvd(q_s[SEC_CNT_W-1:0]), .in_side(ms_s),
        .out_valid(v_min), .out_quot(q_min), .out_rem(sec_min), .out_side(ms_min)
    );

    tcf_cdiv #(.W(MIN_CNT_W), .DIVISOR(MIN_PER_HOUR), .SW(SEC_W + MSEC_W)) u_div_hr (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_min), .in_dvd(q_min[MIN_CNT_W-1:0]), .in_side({sec_min, ms_min}),
        .out_valid(v_hr), .out_quot(q_hr), .out_rem(min_hr), .out_side({sec_hr, ms_hr})
    );

    tcf_cdiv #(.W(HOUR_CNT_W), .DIVISOR(HOUR_PER_DAY), .SW(MIN_W + SEC_W + MSEC_W)) u_div_day (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_hr), .in_dvd(q_hr[HOUR_CNT_W-1:0]), .in_side({min_hr, sec_hr, ms_hr}),
        .out_valid(v_day), .out_quot(q_day), .out_rem(hr_day),
        .out_side({tod_day.minute, tod_day.second, tod_day.millisecond})
    );

    assign tod_day.hour = hr_day;

    tcf_cdiv #(.W(DAY_CNT_W), .DIVISOR(DAYS_PER_YEAR), .SW($bits(tcf_time_t))) u_div_yr (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_day), .in_dvd(q_day[DAY_CNT_W-1:0]), .in_side(tod_day),
        .out_valid(v_yr), .out_quot(q_yr), .out_rem(r_yr), .out_side(tod_yr)
    );

    // ---------------- calendar ----------------
    logic        v_date;
    tcf_date_t   date;
    tcf_result_t res;

    tcf_year #(.EPOCH_YEAR(EPOCH_YEAR)) u_year (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_yr), .in_yq(q_yr[YEAR_OFS_W-1:0]), .in_yr(r_yr), .in_tod(tod_yr),
        .out_valid(v_date), .out_date(date)
    );

    tcf_month u_month (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_date), .in_date(date),
        .out_valid(m_tvalid), .out_res(res)
    );

    // ---------------- output word ----------------
    assign m_tdata = {5'b0, res.weekday, res.millisecond, res.second, res.minute,
                      res.hour, res.day_of_month, res.month, res.year};
    assign m_tuser = res.out_of_range;

    // ---------------- checks ----------------
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("out-of-range word carries nonzero fields");

    a_date_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> ((res.month >= 4'd1) && (res.month <= 4'd12) &&
                                    (res.day_of_month >= 5'd1) && (res.weekday <= 3'd6)))
        else $error("month, day or weekday out of range");

    a_time_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((res.hour < 5'd24) && (res.minute < 6'd60) &&
                      (res.second < 6'd60) && (res.millisecond < 10'd1000)))
        else $error("time of day out of range");

    a_no_idle_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

endmodule

>>> verif/ticks_to_calendar_fields_top_tb.sv
// Self-checking bench for ticks_to_calendar_fields_top: directed and random timestamps.
// Needs tcf_pkg and the converter RTL; expected calendar words come from a local predictor or typed probes.
`timescale 1ns / 100ps

module ticks_to_calendar_fields_top_tb;
    import tcf_pkg::*;

    localparam int unsigned     EPOCH         = 1601;
    localparam longint unsigned TICKS_PER_DAY = 64'd864_000_000_000;
    localparam longint unsigned TICK_MAX      = 64'h03FF_FFFF_FFFF_FFFF;
    localparam int              RANDOM_WORDS  = 400;
    localparam int              LIMIT_CYCLES  = 300_000;
    localparam int              TAIL_CYCLES   = 60;

    typedef enum int unsigned {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_PERIODIC,
        DRAIN_SPARSE
    } drain_mode_t;

    typedef enum int unsigned {
        PICK_UNIFORM,
        PICK_YEAR_EDGE,
        PICK_MONTH_EDGE,
        PICK_SHORT,
        PICK_NEAR_MAX
    } pick_t;

    // One directed probe: a typed expectation or one left to the predictor
    typedef struct {
        logic [63:0] word;
        bit          typed;
        tcf_result_t want;
    } probe_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    tcf_result_t dates_due[$];
    probe_t      probes[$];

    int unsigned fail_count = 0;
    int unsigned words_sent = 0;
    int unsigned dates_seen = 0;
    int unsigned leap_days_seen = 0;
    int unsigned first_year = 4095;
    int unsigned last_year = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;

    drain_mode_t drain_mode = DRAIN_FREE;
    int unsigned drain_left = 0;
    int unsigned drain_phase = 0;

    tcf_result_t want_date;
    tcf_result_t got_date;

    ticks_to_calendar_fields_top #(
        .EPOCH_YEAR (EPOCH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------- calendar predictor ----------------

    function automatic bit has_feb29(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Leap years in 1 .. y-1
    function automatic int unsigned leaps_through(input int unsigned y);
        int unsigned p;
        p = (y == 0) ? 0 : y - 1;
        return p / 4 - p / 100 + p / 400;
    endfunction

    // Days from the epoch's 1 January to 1 January of year y
    function automatic int unsigned year_start(input int unsigned y);
        if (y <= EPOCH) begin
            return 0;
        end
        return (y - EPOCH) * 365 + (leaps_through(y) - leaps_through(EPOCH));
    endfunction

    // Days from 1 January to the first of month m (1..13)
    function automatic int unsigned month_start(input int unsigned y, input int unsigned m);
        int unsigned idx;
        idx = (m == 0) ? 0 : m - 1;
        if (idx > 12) begin
            idx = 12;
        end
        return int'(CUM_DAYS[idx]) + ((has_feb29(y) && m > 2) ? 1 : 0);
    endfunction

    function automatic tcf_result_t calendar_of_ticks(input logic [57:0] ticks);
        longint unsigned rest;
        int unsigned     ms, sec, mins, hr, days, base_wd, yr, ytd, doy, mon;
        tcf_result_t     r;
        rest = ticks;
        rest = rest / TICKS_PER_MS;
        ms   = 32'(rest % MS_PER_SEC);
        rest = rest / MS_PER_SEC;
        sec  = 32'(rest % SEC_PER_MIN);
        rest = rest / SEC_PER_MIN;
        mins = 32'(rest % MIN_PER_HOUR);
        rest = rest / MIN_PER_HOUR;
        hr   = 32'(rest % HOUR_PER_DAY);
        days = 32'(rest / HOUR_PER_DAY);

        base_wd = (1 + 365 * ((EPOCH - 1) % 7) + leaps_through(EPOCH)) % 7;

        // year from days / 365, pulled back once if it overshoots
        yr  = days / 365 + EPOCH;
        ytd = year_start(yr);
        if (ytd > days) begin
            yr--;
            ytd = year_start(yr);
        end

        r = '0;
        if (yr > 4095) begin
            r.out_of_range = 1'b1;
            return r;
        end

        // month guess from doy / 31, bumped once
        doy = days - ytd;
        mon = doy / 31 + 1;
        if (mon > 12) begin
            mon = 12;
        end
        if (doy >= month_start(yr, mon + 1) && mon < 12) begin
            mon++;
        end

        r.year         = YEAR_W'(yr);
        r.month        = MONTH_W'(mon);
        r.day_of_month = MDAY_W'(doy - month_start(yr, mon) + 1);
        r.hour         = HOUR_W'(hr);
        r.minute       = MIN_W'(mins);
        r.second       = SEC_W'(sec);
        r.millisecond  = MSEC_W'(ms);
        r.weekday      = WDAY_W'((days + base_wd) % 7);
        return r;
    endfunction

    // Tick count of a given year, day of year and time of day
    function automatic longint unsigned ticks_at(input int unsigned y, input int unsigned doy,
                                                 input longint unsigned tod);
        return longint'(year_start(y) + doy) * TICKS_PER_DAY + tod;
    endfunction

    function automatic tcf_result_t civil(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s,
                                          input int unsigned ms, input int unsigned wd);
        tcf_result_t r;
        r              = '0;
        r.year         = YEAR_W'(y);
        r.month        = MONTH_W'(mo);
        r.day_of_month = MDAY_W'(d);
        r.hour         = HOUR_W'(h);
        r.minute       = MIN_W'(mi);
        r.second       = SEC_W'(s);
        r.millisecond  = MSEC_W'(ms);
        r.weekday      = WDAY_W'(wd);
        return r;
    endfunction

    // ---------------- directed probes ----------------

    task automatic add_typed(input logic [63:0] word, input tcf_result_t want);
        probes.push_back('{word, 1'b1, want});
    endtask

    task automatic add_probe(input logic [63:0] word);
        probes.push_back('{word, 1'b0, '0});
    endtask

    task automatic build_probes();
        // epoch start is a Monday; sub-millisecond ticks vanish
        add_typed(64'd0,      civil(1601, 1, 1, 0, 0, 0, 0, 1));
        add_typed(64'd9_999,  civil(1601, 1, 1, 0, 0, 0, 0, 1));
        add_typed(64'd10_000, civil(1601, 1, 1, 0, 0, 0, 1, 1));
        add_typed(64'hFC00_0000_0000_0000, civil(1601, 1, 1, 0, 0, 0, 0, 1));
        add_typed(TICKS_PER_DAY + 64'd36_610_010_000, civil(1601, 1, 2, 1, 1, 1, 1, 2));
        add_typed(TICKS_PER_DAY * 365 - 1, civil(1601, 12, 31, 23, 59, 59, 999, 1));
        add_typed(TICKS_PER_DAY * 365,     civil(1602, 1, 1, 0, 0, 0, 0, 2));
        // leap days, century rules, and the year estimate needing its correction
        add_probe(ticks_at(1604, 59, TICKS_PER_DAY / 2));
        add_probe(ticks_at(1604, 365, TICKS_PER_DAY - 1));
        add_probe(ticks_at(1605, 0, 0));
        add_probe(ticks_at(1700, 58, TICKS_PER_DAY - 1));
        add_probe(ticks_at(1700, 59, 0));
        add_probe(ticks_at(2000, 59, 0));
        add_probe(ticks_at(2000, 365, TICKS_PER_DAY - 1));
        add_probe(ticks_at(2400, 365, TICKS_PER_DAY - 1));
        add_probe(ticks_at(2513, 364, TICKS_PER_DAY - 1));
        // field extremes and bit patterns; unused top bits must be ignored
        add_probe(TICK_MAX);
        add_probe(64'hFFFF_FFFF_FFFF_FFFF);
        add_probe(64'h0200_0000_0000_0000);
        add_probe(64'h02AA_AAAA_AAAA_AAAA);
        add_probe(64'h0155_5555_5555_5555);
    endtask

    // Random timestamp: uniform, near year or month boundaries, short, or near the maximum
    function automatic logic [63:0] random_word();
        longint unsigned word, tod;
        int unsigned     y, m, doy, year_len;
        pick_t           pick;
        pick = pick_t'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
            0:       tod = 0;
            1:       tod = TICKS_PER_DAY - 1;
            default: tod = {$urandom, $urandom} % TICKS_PER_DAY;
        endcase
        y        = $urandom_range(EPOCH, 2513);
        year_len = year_start(y + 1) - year_start(y);
        case (pick)
            PICK_UNIFORM: begin
                word = {$urandom, $urandom} & TICK_MAX;
            end
            PICK_YEAR_EDGE: begin
                doy  = $urandom_range(0, 1) ? $urandom_range(0, 2)
                                            : year_len - $urandom_range(1, 3);
                word = ticks_at(y, doy, tod);
            end
            PICK_MONTH_EDGE: begin
                m    = $urandom_range(1, 12);
                doy  = $urandom_range(0, 1) ? month_start(y, m) : month_start(y, m + 1) - 1;
                word = ticks_at(y, doy, tod);
            end
            PICK_SHORT: begin
                word = {$urandom, $urandom} >> $urandom_range(10, 50);
                word = word & TICK_MAX;
            end
            default: begin
                word = TICK_MAX - $urandom_range(0, 32'h7FFF_FFFF);
            end
        endcase
        // now and then set the unused top bits
        if ($urandom_range(0, 7) == 0) begin
            word[63:58] = 6'($urandom);
        end
        return word;
    endfunction

    // ---------------- sender ----------------

    // Called at a falling edge; returns at the falling edge after the word is taken
    task automatic push_tick(input logic [63:0] word, input tcf_result_t want);
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        dates_due.push_back(want);
        words_sent++;
        @(negedge aclk);
    endtask

    // Bursts of random length with random gaps between them
    task automatic pace();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge aclk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    endtask

    // Hold off until every converted date has come back
    task automatic drain_all();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (dates_due.size() != 0);
    endtask

    initial begin
        logic [63:0] word;
        tcf_result_t want;
        build_probes();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (probes[i]) begin
            want = probes[i].typed ? probes[i].want : calendar_of_ticks(probes[i].word[57:0]);
            push_tick(probes[i].word, want);
            pace();
        end
        drain_all();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            word = random_word();
            push_tick(word, calendar_of_ticks(word[57:0]));
            if (n == RANDOM_WORDS / 2) begin
                drain_all();
            end else begin
                pace();
            end
        end
        drain_all();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Converted %0d timestamps (%0d directed), years %0d to %0d, %0d on Feb 29.",
                 words_sent, probes.size(), first_year, last_year, leap_days_seen);
        $display("Results checked: %0d, failures: %0d.", dates_seen, fail_count);
        if (fail_count == 0) begin
            $display("[ticks_to_calendar_fields_top] OK");
        end else begin
            $display("[ticks_to_calendar_fields_top] ERROR");
        end
        $finish;
    end

    // ---------------- receiver back-pressure ----------------

    always @(negedge aclk) begin
        if (drain_left == 0) begin
            drain_mode = drain_mode_t'($urandom_range(0, 3));
            drain_left = $urandom_range(16, 160);
        end else begin
            drain_left--;
        end
        drain_phase++;
        case (drain_mode)
            DRAIN_FREE:     m_tready <= 1'b1;
            DRAIN_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
            DRAIN_PERIODIC: m_tready <= ((drain_phase % 7) >= 3);
            default:        m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // ---------------- result checker ----------------

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 40) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (dates_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 40) begin
                    $display("%0t ns: unexpected word, got %h / %b", $time, m_tdata, m_tuser);
                end
            end else begin
                want_date = dates_due.pop_front();
                got_date  = tcf_result_t'({m_tuser, m_tdata[50:0]});
                check_field("year",         32'(want_date.year),         32'(got_date.year));
                check_field("month",        32'(want_date.month),        32'(got_date.month));
                check_field("day_of_month", 32'(want_date.day_of_month),
                            32'(got_date.day_of_month));
                check_field("hour",         32'(want_date.hour),         32'(got_date.hour));
                check_field("minute",       32'(want_date.minute),       32'(got_date.minute));
                check_field("second",       32'(want_date.second),       32'(got_date.second));
                check_field("millisecond",  32'(want_date.millisecond),
                            32'(got_date.millisecond));
                check_field("weekday",      32'(want_date.weekday),      32'(got_date.weekday));
                check_field("out_of_range", 32'(want_date.out_of_range),
                            32'(got_date.out_of_range));
                check_field("zero fill",    32'(0),                      32'(m_tdata[55:51]));
                dates_seen++;
                if (32'(want_date.year) < first_year) first_year = 32'(want_date.year);
                if (32'(want_date.year) > last_year) last_year = 32'(want_date.year);
                if (want_date.month == 2 && want_date.day_of_month == 29) leap_days_seen++;
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d dates still due.", cycle_count,
                     dates_due.size());
            $display("[ticks_to_calendar_fields_top] ERROR");
            $finish;
        end
    end

endmodule

>>> files.f
sv/tcf_pkg.sv
sv/tcf_cdiv.sv
sv/tcf_year.sv
sv/tcf_month.sv
sv/ticks_to_calendar_fields_top.sv
verif/ticks_to_calendar_fields_top_tb.sv
